// ----- hdl/text_to_code_point_decoder_assert.svh -----
// Assertion macros used by the checker of the text to code point decoder.
// Depends on nothing; each user supplies the clock and reset names it is given.
`ifndef TEXT_TO_CODE_POINT_DECODER_ASSERT_SVH
`define TEXT_TO_CODE_POINT_DECODER_ASSERT_SVH

// same-cycle implication
`define TTCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ttcp_pkg.sv -----
// Shared types and constants of the text to code point decoder.
// Used by the decode step, the top level and the port checker.
package ttcp_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_ENCODING    = 2'd0;
   localparam logic [1:0] REG_BYTE_ORDER  = 2'd1;
   localparam logic [1:0] REG_DETECT_MARK = 2'd2;

   // encodings; the unused code decodes as UCS-2
   localparam logic [1:0] ENC_UTF8  = 2'd0;
   localparam logic [1:0] ENC_UTF16 = 2'd1;
   localparam logic [1:0] ENC_UCS2  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_CHAR     = 2'd0;
   localparam logic [1:0] KIND_MARK_BE  = 2'd1;
   localparam logic [1:0] KIND_MARK_LE  = 2'd2;
   localparam logic [1:0] KIND_NO_MARK  = 2'd3;

   // decoder phases
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_MARK  = 3'd1;
   localparam logic [2:0] PH_UTF8  = 3'd2;
   localparam logic [2:0] PH_UNIT  = 3'd3;
   localparam logic [2:0] PH_LOW_A = 3'd4;
   localparam logic [2:0] PH_LOW_B = 3'd5;

   localparam int CP_WIDTH = 22;

   localparam logic [15:0] SURR_FIRST  = 16'hD800;
   localparam logic [15:0] SURR_LAST   = 16'hDFFF;
   localparam logic [15:0] LOW_BASE    = 16'hDC00;
   localparam logic [CP_WIDTH-1:0] PLANE_BASE = 22'h010000;
   localparam logic [7:0]  MARK_FE     = 8'hFE;
   localparam logic [7:0]  MARK_FF     = 8'hFF;

   typedef struct packed {
      logic [1:0] encoding;
      logic       byte_order;
      logic       detect_mark;
   } cfg_type;

   typedef struct packed {
      logic [2:0]          phase;
      logic [2:0]          bytes_needed;
      logic [CP_WIDTH-1:0] accumulator;
      logic [7:0]          held_byte;
      logic [15:0]         high_unit;
      logic                active_order;
      logic                mark_pending;
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [CP_WIDTH-1:0] code_point;
      logic [1:0]          kind;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase: PH_IDLE, bytes_needed: 3'd0, accumulator: '0, held_byte: 8'd0,
      high_unit: 16'd0, active_order: 1'b0, mark_pending: 1'b1};

endpackage

// ----- hdl/text_to_code_point_decoder.sv -----
// Top level of the text to code point decoder: input register, decode step,
// result register and configuration registers. Depends on ttcp_pkg, ttcp_step.
//
// Usage:
//   req_* carries one byte of encoded text per word, with req_start_of_text
//   marking the first byte of a new text. rsp_* carries a decoded code point
//   or a byte order mark report (rsp_kind); bytes that only extend a character
//   give no word. csr_* writes encoding, byte_order and detect_mark; write
//   them only while no byte is in flight. csr_ready is always high.
//   An accepted byte passes the input register, then the result register,
//   before its word appears on rsp_*. One byte is taken every cycle while the
//   receiver does not stall; the rate is set by the single decode step between
//   the two registers, which also updates the decoder state.
//   When the receiver stalls, the result register holds its word, the byte in
//   the input register waits, and req_ready drops once both are full.
//   Reset clears the configuration to UTF-8, big endian, no mark detection,
//   empties both registers and puts the decoder at the start of a text.
module text_to_code_point_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [21:0] rsp_code_point,
   output logic [1:0]  rsp_kind,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_data
);

   ttcp_pkg::cfg_type    cfg_ff, cfg_in;
   ttcp_pkg::state_type  state_ff, state_in;
   ttcp_pkg::result_type step_result;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       sot_ff;
   logic       out_valid_ff, out_valid_in;
   logic [21:0] code_point_ff;
   logic [1:0]  kind_ff;
   logic       advance;
   logic       req_accept;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ttcp_pkg::REG_ENCODING:    cfg_in.encoding    = csr_data;
            ttcp_pkg::REG_BYTE_ORDER:  cfg_in.byte_order  = csr_data[0];
            ttcp_pkg::REG_DETECT_MARK: cfg_in.detect_mark = csr_data[0];
            default: ;
         endcase
      end
   end

   ttcp_step u_step (
      .cfg           (cfg_ff),
      .state_cur     (state_ff),
      .data_byte     (byte_ff),
      .start_of_text (sot_ff),
      .state_next    (state_in),
      .result        (step_result)
   );

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance ? step_result.valid : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         state_ff     <= ttcp_pkg::STATE_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byte_ff <= req_data_byte;
         sot_ff  <= req_start_of_text;
      end
      if (advance && step_result.valid) begin
         code_point_ff <= step_result.code_point;
         kind_ff       <= step_result.kind;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = code_point_ff;
   assign rsp_kind       = kind_ff;

endmodule

// ----- hdl/ttcp_step.sv -----
// One decode step: next decoder state and the optional result for one byte.
// Purely combinational; depends on ttcp_pkg.
module ttcp_step (
   input  ttcp_pkg::cfg_type    cfg,
   input  ttcp_pkg::state_type  state_cur,
   input  logic [7:0]           data_byte,
   input  logic                 start_of_text,
   output ttcp_pkg::state_type  state_next,
   output ttcp_pkg::result_type result
);

   logic [15:0] pair_unit;
   logic        first_byte;

   // 16-bit unit from the held byte and this one, in the active order
   always_comb begin
      logic order_le;
      order_le  = state_cur.active_order;
      if (start_of_text || (state_cur.mark_pending && state_cur.phase == ttcp_pkg::PH_IDLE)) begin
         order_le = cfg.byte_order;
      end
      pair_unit = order_le ? {data_byte, state_cur.held_byte}
                           : {state_cur.held_byte, data_byte};
   end

   always_comb begin
      ttcp_pkg::state_type st;
      logic [ttcp_pkg::CP_WIDTH-1:0] cp_pair;
      logic [ttcp_pkg::CP_WIDTH-1:0] acc_next;
      logic [2:0]                    need_next;
      logic                          done;

      st         = state_cur;
      result     = '{valid: 1'b0, code_point: '0, kind: ttcp_pkg::KIND_CHAR};
      done       = 1'b0;
      first_byte = 1'b0;

      if (start_of_text) begin
         st              = ttcp_pkg::STATE_RESET;
         st.active_order = state_cur.active_order;
      end

      // first byte of a text picks up the order and maybe starts the mark
      if (st.mark_pending && st.phase == ttcp_pkg::PH_IDLE) begin
         st.active_order = cfg.byte_order;
         st.mark_pending = 1'b0;
         if (cfg.detect_mark) begin
            st.held_byte = data_byte;
            st.phase     = ttcp_pkg::PH_MARK;
            done         = 1'b1;
         end
      end

      cp_pair = (({6'd0, st.high_unit} - {6'd0, ttcp_pkg::SURR_FIRST}) << 10)
              + ({6'd0, pair_unit} - {6'd0, ttcp_pkg::LOW_BASE})
              + ttcp_pkg::PLANE_BASE;
      acc_next  = {st.accumulator[ttcp_pkg::CP_WIDTH-7:0], data_byte[5:0]};
      need_next = st.bytes_needed - 3'd1;

      if (!done) begin
         unique case (st.phase)
            ttcp_pkg::PH_MARK: begin
               st.phase     = ttcp_pkg::PH_IDLE;
               result.valid = 1'b1;
               if (st.held_byte == ttcp_pkg::MARK_FE && data_byte == ttcp_pkg::MARK_FF) begin
                  st.active_order = 1'b0;
                  result.kind     = ttcp_pkg::KIND_MARK_BE;
               end else if (st.held_byte == ttcp_pkg::MARK_FF &&
                            data_byte == ttcp_pkg::MARK_FE) begin
                  st.active_order = 1'b1;
                  result.kind     = ttcp_pkg::KIND_MARK_LE;
               end else begin
                  result.kind = ttcp_pkg::KIND_NO_MARK;
               end
            end
            ttcp_pkg::PH_UTF8: begin
               st.accumulator  = acc_next;
               st.bytes_needed = need_next;
               if (need_next == 3'd0) begin
                  st.phase          = ttcp_pkg::PH_IDLE;
                  result.valid      = 1'b1;
                  result.code_point = acc_next;
               end
            end
            ttcp_pkg::PH_UNIT: begin
               if (cfg.encoding == ttcp_pkg::ENC_UTF16 && pair_unit >= ttcp_pkg::SURR_FIRST &&
                   pair_unit <= ttcp_pkg::SURR_LAST) begin
                  st.high_unit = pair_unit;
                  st.phase     = ttcp_pkg::PH_LOW_A;
               end else begin
                  st.phase          = ttcp_pkg::PH_IDLE;
                  result.valid      = 1'b1;
                  result.code_point = {6'd0, pair_unit};
               end
            end
            ttcp_pkg::PH_LOW_A: begin
               st.held_byte = data_byte;
               st.phase     = ttcp_pkg::PH_LOW_B;
            end
            ttcp_pkg::PH_LOW_B: begin
               st.phase          = ttcp_pkg::PH_IDLE;
               result.valid      = 1'b1;
               result.code_point = cp_pair;
            end
            default: begin
               // idle and unused phase codes both start a character
               first_byte = 1'b1;
            end
         endcase
      end

      if (first_byte) begin
         if (cfg.encoding == ttcp_pkg::ENC_UTF8) begin
            if (!data_byte[7]) begin
               result.valid      = 1'b1;
               result.code_point = {14'd0, data_byte};
            end else begin
               st.phase = ttcp_pkg::PH_UTF8;
               if (!data_byte[5]) begin
                  st.accumulator  = {16'd0, data_byte[5:0]};
                  st.bytes_needed = 3'd1;
               end else if (!data_byte[4]) begin
                  st.accumulator  = {17'd0, data_byte[4:0]};
                  st.bytes_needed = 3'd2;
               end else begin
                  st.accumulator  = {18'd0, data_byte[3:0]};
                  st.bytes_needed = 3'd3;
               end
            end
         end else begin
            st.held_byte = data_byte;
            st.phase     = ttcp_pkg::PH_UNIT;
         end
      end

      state_next = st;
   end

endmodule

// ----- hdl/ttcp_checker.sv -----
// Port-level checker for the text to code point decoder, bound to the top.
// Depends on ttcp_pkg and text_to_code_point_decoder_assert.svh.
`include "text_to_code_point_decoder_assert.svh"

module ttcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_data_byte,
   input logic        req_start_of_text,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [21:0] rsp_code_point,
   input logic [1:0]  rsp_kind,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [1:0]  csr_data
);

   // mark reports carry no code point
   `TTCP_ASSERT_NOW(a_mark_zero, clock, reset,
      rsp_valid && rsp_kind != ttcp_pkg::KIND_CHAR, rsp_code_point == 22'd0,
      "mark report with nonzero code point")

   // a fresh word needs a byte taken earlier, through the input and result registers
   `TTCP_ASSERT_NOW(a_rsp_latency, clock, reset,
      $rose(rsp_valid), $past(req_valid && req_ready, 2),
      "word without a byte two cycles before")

   `TTCP_ASSERT_NOW(a_rsp_reset, clock, reset,
      $past(reset), !rsp_valid,
      "word present right after reset")

   `TTCP_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code_point) && $stable(rsp_kind),
      "stalled word changed")

endmodule

bind text_to_code_point_decoder ttcp_checker u_ttcp_checker (.*);

// ----- tb/text_to_code_point_decoder_test.sv -----
// Self-checking bench for text_to_code_point_decoder: a directed stimulus table, then random
// texts under several encodings, checked word by word against a built-in decoder.
// Depends on ttcp_pkg and the text_to_code_point_decoder RTL.
module text_to_code_point_decoder_test;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 222;
   // unused encoding code
   localparam logic [1:0] ENC_SPARE = 2'd3;
   // per phase {encoding, byte_order, detect_mark}, phase 0 in the low bits
   localparam logic [35:0] PHASE_PLAN = {4'b0000, 4'b1001, 4'b0111, 4'b0010, 4'b1101,
                                         4'b0110, 4'b1010, 4'b0101, 4'b0001};

   typedef struct packed {
      logic [ttcp_pkg::CP_WIDTH-1:0] code_point;
      logic [1:0]                    kind;
   } word_type;

   typedef struct packed {
      logic       sot;
      logic [7:0] data;
   } stim_type;

   typedef struct packed {
      logic [1:0]                    enc;
      logic                          ord;
      logic                          mark;
      logic                          sot;
      logic [7:0]                    data;
      logic                          typed;
      logic                          has_word;
      logic [ttcp_pkg::CP_WIDTH-1:0] cp;
      logic [1:0]                    kind;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_start_of_text;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [21:0] rsp_code_point;
   logic [1:0]  rsp_kind;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [1:0]  csr_data;

   // typed expectation riding along with the word on req_*
   logic                          row_typed;
   logic                          row_has_word;
   logic [ttcp_pkg::CP_WIDTH-1:0] row_cp;
   logic [1:0]                    row_kind;

   ttcp_pkg::state_type dec_state;
   ttcp_pkg::cfg_type   live_cfg;
   ttcp_pkg::cfg_type   set_cfg;
   word_type   pending_words[$];
   stim_type   text_bytes[$];
   row_type    directed_rows[$];
   logic       next_sot;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         fault_count;
   int         stall_cycles;
   int         sent_count;

   logic                          made_word;
   logic [ttcp_pkg::CP_WIDTH-1:0] pred_cp;
   logic [1:0]                    pred_kind;
   word_type                      head;

   text_to_code_point_decoder DUT (.*);

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] join_bytes(input logic order, input logic [7:0] first,
                                              input logic [7:0] second);
      return order ? {second, first} : {first, second};
   endfunction

   // one byte through the decoder; state and configuration are the bench's own copies
   function automatic void decode_byte(input logic sot, input logic [7:0] b,
                                       output logic produced,
                                       output logic [ttcp_pkg::CP_WIDTH-1:0] cp,
                                       output logic [1:0] kind);
      logic [15:0] unit;
      logic        took_mark;
      produced = 1'b0;
      cp = '0;
      kind = ttcp_pkg::KIND_CHAR;
      took_mark = 1'b0;
      if (sot) begin
         dec_state.phase = ttcp_pkg::PH_IDLE;
         dec_state.bytes_needed = '0;
         dec_state.accumulator = '0;
         dec_state.held_byte = '0;
         dec_state.high_unit = '0;
         dec_state.mark_pending = 1'b1;
      end
      if (dec_state.mark_pending && dec_state.phase == ttcp_pkg::PH_IDLE) begin
         dec_state.active_order = live_cfg.byte_order;
         dec_state.mark_pending = 1'b0;
         if (live_cfg.detect_mark) begin
            dec_state.held_byte = b;
            dec_state.phase = ttcp_pkg::PH_MARK;
            took_mark = 1'b1;
         end
      end
      if (!took_mark) begin
         case (dec_state.phase)
            ttcp_pkg::PH_MARK: begin
               dec_state.phase = ttcp_pkg::PH_IDLE;
               produced = 1'b1;
               if (dec_state.held_byte == ttcp_pkg::MARK_FE && b == ttcp_pkg::MARK_FF) begin
                  dec_state.active_order = 1'b0;
                  kind = ttcp_pkg::KIND_MARK_BE;
               end else if (dec_state.held_byte == ttcp_pkg::MARK_FF &&
                            b == ttcp_pkg::MARK_FE) begin
                  dec_state.active_order = 1'b1;
                  kind = ttcp_pkg::KIND_MARK_LE;
               end else begin
                  kind = ttcp_pkg::KIND_NO_MARK;
               end
            end
            ttcp_pkg::PH_UTF8: begin
               dec_state.accumulator = {dec_state.accumulator[15:0], b[5:0]};
               dec_state.bytes_needed = dec_state.bytes_needed - 3'd1;
               if (dec_state.bytes_needed == 3'd0) begin
                  dec_state.phase = ttcp_pkg::PH_IDLE;
                  produced = 1'b1;
                  cp = dec_state.accumulator;
               end
            end
            ttcp_pkg::PH_UNIT: begin
               unit = join_bytes(dec_state.active_order, dec_state.held_byte, b);
               if (live_cfg.encoding == ttcp_pkg::ENC_UTF16 && unit >= ttcp_pkg::SURR_FIRST &&
                   unit <= ttcp_pkg::SURR_LAST) begin
                  dec_state.high_unit = unit;
                  dec_state.phase = ttcp_pkg::PH_LOW_A;
               end else begin
                  dec_state.phase = ttcp_pkg::PH_IDLE;
                  produced = 1'b1;
                  cp = {6'd0, unit};
               end
            end
            ttcp_pkg::PH_LOW_A: begin
               dec_state.held_byte = b;
               dec_state.phase = ttcp_pkg::PH_LOW_B;
            end
            ttcp_pkg::PH_LOW_B: begin
               unit = join_bytes(dec_state.active_order, dec_state.held_byte, b);
               dec_state.phase = ttcp_pkg::PH_IDLE;
               produced = 1'b1;
               // 22-bit context: pair arithmetic wraps modulo 2^22
               cp = ({6'd0, dec_state.high_unit} - {6'd0, ttcp_pkg::SURR_FIRST}) * 22'd1024
                    + ({6'd0, unit} - {6'd0, ttcp_pkg::LOW_BASE}) + ttcp_pkg::PLANE_BASE;
            end
            default: begin
               if (live_cfg.encoding == ttcp_pkg::ENC_UTF8) begin
                  if (!b[7]) begin
                     produced = 1'b1;
                     cp = {14'd0, b};
                  end else begin
                     if (!b[5]) begin
                        dec_state.accumulator = {16'd0, b[5:0]};
                        dec_state.bytes_needed = 3'd1;
                     end else if (!b[4]) begin
                        dec_state.accumulator = {17'd0, b[4:0]};
                        dec_state.bytes_needed = 3'd2;
                     end else begin
                        dec_state.accumulator = {18'd0, b[3:0]};
                        dec_state.bytes_needed = 3'd3;
                     end
                     dec_state.phase = ttcp_pkg::PH_UTF8;
                  end
               end else begin
                  dec_state.held_byte = b;
                  dec_state.phase = ttcp_pkg::PH_UNIT;
               end
            end
         endcase
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // handshakes are sampled before this edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ttcp_pkg::REG_ENCODING:    live_cfg.encoding = csr_data;
               ttcp_pkg::REG_BYTE_ORDER:  live_cfg.byte_order = csr_data[0];
               ttcp_pkg::REG_DETECT_MARK: live_cfg.detect_mark = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            decode_byte(req_start_of_text, req_data_byte, made_word, pred_cp, pred_kind);
            if (row_typed) begin
               if (row_has_word)
                  pending_words.insert(pending_words.size(), {row_cp, row_kind});
            end else if (made_word) begin
               pending_words.insert(pending_words.size(), {pred_cp, pred_kind});
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               $error("unexpected word: code_point %h kind %0d", rsp_code_point, rsp_kind);
               fault_count++;
            end else begin
               head = pending_words.pop_front();
               if (rsp_code_point !== head.code_point) begin
                  $error("code_point: expected %h, got %h", head.code_point, rsp_code_point);
                  fault_count++;
               end
               if (rsp_kind !== head.kind) begin
                  $error("kind: expected %0d, got %0d", head.kind, rsp_kind);
                  fault_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_word(input logic sot, input logic [7:0] b, input logic typed,
                            input logic has_word, input logic [ttcp_pkg::CP_WIDTH-1:0] cp,
                            input logic [1:0] kind);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_of_text <= sot;
      req_data_byte <= b;
      row_typed <= typed;
      row_has_word <= has_word;
      row_cp <= cp;
      row_kind <= kind;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // sender idle, nothing owed, and the pipeline flushed of bytes with no word
   task automatic wait_quiet;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic wait_csr;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_config(input ttcp_pkg::cfg_type c);
      csr_valid <= 1'b1;
      csr_index <= ttcp_pkg::REG_ENCODING;
      csr_data <= c.encoding;
      wait_csr();
      csr_index <= ttcp_pkg::REG_BYTE_ORDER;
      csr_data <= {1'b0, c.byte_order};
      wait_csr();
      csr_index <= ttcp_pkg::REG_DETECT_MARK;
      csr_data <= {1'b0, c.detect_mark};
      wait_csr();
      csr_valid <= 1'b0;
      set_cfg = c;
   endtask

   task automatic add_row(input logic [1:0] enc, input logic ord, input logic mark,
                          input logic sot, input logic [7:0] data, input logic typed,
                          input logic has_word, input logic [ttcp_pkg::CP_WIDTH-1:0] cp,
                          input logic [1:0] kind);
      directed_rows.insert(directed_rows.size(),
                           {enc, ord, mark, sot, data, typed, has_word, cp, kind});
   endtask

   task automatic push_byte(input logic [7:0] b);
      text_bytes.insert(text_bytes.size(), {next_sot, b});
      next_sot = 1'b0;
   endtask

   task automatic push_unit(input logic [15:0] u, input logic le);
      if (le) begin
         push_byte(u[7:0]);
         push_byte(u[15:8]);
      end else begin
         push_byte(u[15:8]);
         push_byte(u[7:0]);
      end
   endtask

   // mostly well-formed characters of the current encoding, with some noise bytes
   task automatic build_text(input logic with_sot);
      logic [7:0]  b;
      logic [7:0]  c;
      logic [15:0] u;
      logic [15:0] u2;
      logic        le;
      int          pick;
      int          len;
      text_bytes.delete();
      next_sot = with_sot;
      le = set_cfg.byte_order;
      if (with_sot && set_cfg.detect_mark) begin
         pick = $urandom_range(9);
         if (pick < 4) begin
            push_byte(ttcp_pkg::MARK_FE);
            push_byte(ttcp_pkg::MARK_FF);
            le = 1'b0;
         end else if (pick < 8) begin
            push_byte(ttcp_pkg::MARK_FF);
            push_byte(ttcp_pkg::MARK_FE);
            le = 1'b1;
         end else begin
            push_byte(8'($urandom));
            push_byte(8'($urandom));
         end
      end
      repeat ($urandom_range(1, 10)) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            push_byte(8'($urandom));
         end else if (set_cfg.encoding == ttcp_pkg::ENC_UTF8) begin
            len = $urandom_range(1, 4);
            b = 8'($urandom);
            case (len)
               1: b[7] = 1'b0;
               2: {b[7], b[5]} = 2'b10;
               3: {b[7], b[5], b[4]} = 3'b110;
               default: {b[7], b[5], b[4]} = 3'b111;
            endcase
            push_byte(b);
            repeat (len - 1) begin
               c = 8'($urandom);
               if ($urandom_range(9) != 0)
                  c[7:6] = 2'b10;
               push_byte(c);
            end
         end else begin
            u = 16'($urandom);
            u2 = 16'($urandom);
            if (pick < 40) begin
               u[15:10] = 6'b110110;
               u2[15:10] = 6'b110111;
               push_unit(u, le);
               push_unit(u2, le);
            end else if (pick < 46) begin
               // any surrogate first, partner unchecked
               u[15:11] = 5'b11011;
               push_unit(u, le);
               push_unit(u2, le);
            end else begin
               push_unit(u, le);
            end
         end
      end
   endtask

   initial begin
      row_type           r;
      stim_type          s;
      ttcp_pkg::cfg_type c;
      int                text_no;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_start_of_text = 1'b0;
      csr_valid = 1'b0;
      csr_index = ttcp_pkg::REG_ENCODING;
      csr_data = '0;
      row_typed = 1'b0;
      row_has_word = 1'b0;
      row_cp = '0;
      row_kind = ttcp_pkg::KIND_CHAR;
      dec_state = ttcp_pkg::STATE_RESET;
      live_cfg = '0;
      set_cfg = '0;
      fault_count = 0;
      stall_cycles = 0;
      sent_count = 0;
      send_idle_pct = 29;
      recv_idle_pct = 62;

      // UTF-8 after reset: extremes, 2-byte, 4-byte max, new text mid character
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b1, 8'h00,
              1'b1, 1'b1, 22'h000000, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b0, 8'h7F,
              1'b1, 1'b1, 22'h00007F, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b0, 8'hC3,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b0, 8'hA9,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b0, 8'hFF,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b0, 8'hFF,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b0, 8'hFF,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b0, 8'hFF,
              1'b1, 1'b1, 22'h3FFFFF, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b0, 8'hE2,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b0, 8'h82,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF8, 1'b0, 1'b0, 1'b1, 8'h41,
              1'b1, 1'b1, 22'h000041, ttcp_pkg::KIND_CHAR);
      // UTF-16 with mark detection: both marks, a pair, low surrogate first, no mark
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b1, 8'hFE,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'hFF,
              1'b1, 1'b1, 22'h000000, ttcp_pkg::KIND_MARK_BE);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'hD8,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'h00,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'hDC,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'h00,
              1'b1, 1'b1, 22'h010000, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b1, 8'hFF,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'hFE,
              1'b1, 1'b1, 22'h000000, ttcp_pkg::KIND_MARK_LE);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'hFF,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'hDF,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'h00,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'h00,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b1, 8'h12,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ttcp_pkg::ENC_UTF16, 1'b0, 1'b1, 1'b0, 8'h34,
              1'b1, 1'b1, 22'h000000, ttcp_pkg::KIND_NO_MARK);
      // unused encoding code decodes as UCS-2, little endian
      add_row(ENC_SPARE, 1'b1, 1'b0, 1'b1, 8'hFF,
              1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
      add_row(ENC_SPARE, 1'b1, 1'b0, 1'b0, 8'hFF,
              1'b1, 1'b1, 22'h00FFFF, ttcp_pkg::KIND_CHAR);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if ({r.enc, r.ord, r.mark} != set_cfg) begin
            wait_quiet();
            write_config({r.enc, r.ord, r.mark});
         end
         send_word(r.sot, r.data, r.typed, r.has_word, r.cp, r.kind);
      end

      for (int ph = 0; ph < 9; ph++) begin
         wait_quiet();
         send_idle_pct = ph < 3 ? 29 : (ph < 6 ? 62 : 0);
         recv_idle_pct = ph < 3 ? 62 : (ph < 6 ? 29 : 0);
         c = PHASE_PLAN[ph*4 +: 4];
         write_config(c);
         sent_count = 0;
         text_no = 0;
         // first text carries on from the last phase: config change mid character
         while (sent_count < PHASE_ITEMS) begin
            build_text(text_no == 0 ? 1'b0 : ($urandom_range(9) != 0));
            if (text_no == 3)
               wait_quiet();
            foreach (text_bytes[i]) begin
               s = text_bytes[i];
               send_word(s.sot, s.data, 1'b0, 1'b0, '0, ttcp_pkg::KIND_CHAR);
            end
            text_no++;
         end
      end

      wait_quiet();
      if (fault_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
